// File: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Each check is sampled on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define CHK_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_IMPLIES(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/paqi_pkg.sv
// Package for the particulate air quality index: breakpoint tables, reciprocals, types.
// No dependencies.
`timescale 1ns / 1ps
package paqi_pkg;

    localparam int SEGMENTS    = 6;
    localparam int SEG_W       = 3;
    localparam int CONC_W      = 13;
    localparam int OFF_W       = 12;
    localparam int NUM_W       = 20;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 34;
    localparam int QUOT_W      = 8;
    localparam int SUB_W       = 9;
    localparam int INDEX_W     = 10;
    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

    typedef logic [SEG_W-1:0] seg_t;

    typedef struct packed {
        logic             ok;
        logic [SUB_W-1:0] value;
    } sub_t;

    typedef enum logic [2:0] {
        CAT_GOOD,
        CAT_MODERATE,
        CAT_SENSITIVE,
        CAT_UNHEALTHY,
        CAT_VERY_UNHEALTHY,
        CAT_HAZARDOUS
    } cat_t;

    // fine table in tenths of ug/m3 (PM1, PM2.5), coarse in whole ug/m3 (PM10)
    localparam logic [CONC_W-1:0] FINE_LO [SEGMENTS] =
        '{13'd0, 13'd121, 13'd355, 13'd555, 13'd1505, 13'd2505};
    localparam logic [CONC_W-1:0] FINE_HI [SEGMENTS] =
        '{13'd120, 13'd354, 13'd554, 13'd1504, 13'd2504, 13'd5004};
    localparam logic [CONC_W-1:0] COARSE_LO [SEGMENTS] =
        '{13'd0, 13'd55, 13'd155, 13'd255, 13'd355, 13'd425};
    localparam logic [CONC_W-1:0] COARSE_HI [SEGMENTS] =
        '{13'd54, 13'd154, 13'd254, 13'd354, 13'd424, 13'd604};

    localparam logic [OFF_W-1:0] FINE_SPAN [SEGMENTS] =
        '{12'd120, 12'd233, 12'd199, 12'd949, 12'd999, 12'd2499};
    localparam logic [OFF_W-1:0] COARSE_SPAN [SEGMENTS] =
        '{12'd54, 12'd99, 12'd99, 12'd99, 12'd69, 12'd179};

    // twice the index rise of each segment, and its index floor
    localparam logic [SUB_W-1:0] SLOPE2 [SEGMENTS] =
        '{9'd100, 9'd98, 9'd98, 9'd98, 9'd198, 9'd398};
    localparam logic [SUB_W-1:0] A_LO [SEGMENTS] =
        '{9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301};

    // ceil(2^34 / (2 * span)); exact quotient for numerators below 2^20
    localparam logic [RECIP_W-1:0] FINE_RECIP [SEGMENTS] = '{
        RECIP_W'((RECIP_ONE + 64'd239) / 64'd240),
        RECIP_W'((RECIP_ONE + 64'd465) / 64'd466),
        RECIP_W'((RECIP_ONE + 64'd397) / 64'd398),
        RECIP_W'((RECIP_ONE + 64'd1897) / 64'd1898),
        RECIP_W'((RECIP_ONE + 64'd1997) / 64'd1998),
        RECIP_W'((RECIP_ONE + 64'd4997) / 64'd4998)
    };
    localparam logic [RECIP_W-1:0] COARSE_RECIP [SEGMENTS] = '{
        RECIP_W'((RECIP_ONE + 64'd107) / 64'd108),
        RECIP_W'((RECIP_ONE + 64'd197) / 64'd198),
        RECIP_W'((RECIP_ONE + 64'd197) / 64'd198),
        RECIP_W'((RECIP_ONE + 64'd197) / 64'd198),
        RECIP_W'((RECIP_ONE + 64'd137) / 64'd138),
        RECIP_W'((RECIP_ONE + 64'd357) / 64'd358)
    };

endpackage

// File: sv/paqi_lane.sv
// One sub-index lane: segment search, interpolation numerator, reciprocal divide, offset add.
// Four register stages advanced by a shared enable. Depends on paqi_pkg.
`timescale 1ns / 1ps
module paqi_lane
(
    input  logic                         clk,
    input  logic                         en,
    input  logic                         coarse,
    input  logic [paqi_pkg::CONC_W-1:0]  conc,
    output paqi_pkg::sub_t               sub
);

    // stage 1: segment and offset
    logic                          ok1_reg, ok1_next;
    paqi_pkg::seg_t                seg1_reg, seg1_next;
    logic [paqi_pkg::OFF_W-1:0]    off1_reg, off1_next;
    logic [paqi_pkg::CONC_W-1:0]   diff1;

    // stage 2: rounding numerator
    logic                          ok2_reg;
    paqi_pkg::seg_t                seg2_reg;
    logic [paqi_pkg::NUM_W-1:0]    num2_reg, num2_next;
    logic [paqi_pkg::NUM_W:0]      mul2;
    logic [paqi_pkg::OFF_W-1:0]    span2;

    // stage 3: quotient
    logic                          ok3_reg;
    paqi_pkg::seg_t                seg3_reg;
    logic [paqi_pkg::QUOT_W-1:0]   q3_reg, q3_next;
    logic [47:0]                   mul3;
    logic [paqi_pkg::RECIP_W-1:0]  recip3;

    // stage 4: sub-index
    logic                          ok4_reg;
    logic [paqi_pkg::SUB_W-1:0]    sub4_reg, sub4_next;

    always_comb
    begin
        seg1_next = paqi_pkg::seg_t'(paqi_pkg::SEGMENTS - 1);
        for (int k = paqi_pkg::SEGMENTS - 1; k >= 0; k--)
        begin
            if (coarse ? (conc <= paqi_pkg::COARSE_HI[k]) : (conc <= paqi_pkg::FINE_HI[k]))
            begin
                seg1_next = paqi_pkg::seg_t'(k);
            end
        end
        ok1_next = coarse ? (conc <= paqi_pkg::COARSE_HI[paqi_pkg::SEGMENTS-1])
                          : (conc <= paqi_pkg::FINE_HI[paqi_pkg::SEGMENTS-1]);
        diff1 = conc - (coarse ? paqi_pkg::COARSE_LO[seg1_next] : paqi_pkg::FINE_LO[seg1_next]);
        off1_next = diff1[paqi_pkg::OFF_W-1:0];
    end

    always_comb
    begin
        span2 = coarse ? paqi_pkg::COARSE_SPAN[seg1_reg] : paqi_pkg::FINE_SPAN[seg1_reg];
        mul2 = (paqi_pkg::NUM_W+1)'(paqi_pkg::SLOPE2[seg1_reg])
             * (paqi_pkg::NUM_W+1)'(off1_reg);
        num2_next = paqi_pkg::NUM_W'(mul2 + (paqi_pkg::NUM_W+1)'(span2));
    end

    always_comb
    begin
        recip3 = coarse ? paqi_pkg::COARSE_RECIP[seg2_reg] : paqi_pkg::FINE_RECIP[seg2_reg];
        mul3 = 48'(num2_reg) * 48'(recip3);
        q3_next = mul3[paqi_pkg::RECIP_SHIFT +: paqi_pkg::QUOT_W];
    end

    assign sub4_next = paqi_pkg::A_LO[seg3_reg] + paqi_pkg::SUB_W'(q3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok1_reg  <= ok1_next;
            seg1_reg <= seg1_next;
            off1_reg <= off1_next;
            ok2_reg  <= ok1_reg;
            seg2_reg <= seg1_reg;
            num2_reg <= num2_next;
            ok3_reg  <= ok2_reg;
            seg3_reg <= seg2_reg;
            q3_reg   <= q3_next;
            ok4_reg  <= ok3_reg;
            sub4_reg <= sub4_next;
        end
    end

    assign sub.ok    = ok4_reg;
    assign sub.value = sub4_reg;

endmodule

// File: sv/particulate_air_quality_index.sv
// Particulate air quality index, top level: three sub-index lanes and the max/category stage.
// Depends on paqi_pkg, paqi_lane and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one request per reading:
//   pm1_tenths and pm25_tenths in 0.1 ug/m3, pm10_whole in ug/m3.
//   Output channel (out_valid / out_ready) returns one result per request:
//   index_value (signed, -1 when no concentration lies in its table) and
//   health_category (0 good .. 5 hazardous).
//   From acceptance to out_valid a request passes four lane stages
//   (segment search, numerator multiply, reciprocal multiply, offset add)
//   and the output register holding the maximum and category.
//   Throughput is one request per cycle while out_ready is not holding a
//   waiting result; the reciprocal multiply is the deepest stage.
//   Reset clears every valid bit; the pipeline is empty afterwards and
//   in_ready is high.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops in the same cycle; nothing is lost
//   or repeated, and flow resumes as soon as out_ready returns.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module particulate_air_quality_index
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [12:0]                         pm1_tenths,
    input  logic [12:0]                         pm25_tenths,
    input  logic [10:0]                         pm10_whole,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [paqi_pkg::INDEX_W-1:0] index_value,
    output logic [2:0]                          health_category
);

    localparam int STAGES = 5;

    logic [STAGES-1:0]                  v_reg, v_next;
    logic                               en;
    paqi_pkg::sub_t                     sub_p1, sub_p25, sub_p10;
    logic signed [paqi_pkg::INDEX_W-1:0] s_p1, s_p25, s_p10;
    logic signed [paqi_pkg::INDEX_W-1:0] best_next, best_reg;
    paqi_pkg::cat_t                     cat_next, cat_reg;

    assign en       = !v_reg[STAGES-1] || out_ready;
    assign in_ready = en;
    assign v_next   = {v_reg[STAGES-2:0], in_valid};

    paqi_lane u_lane_p1
    (
        .clk    (clk),
        .en     (en),
        .coarse (1'b0),
        .conc   (pm1_tenths),
        .sub    (sub_p1)
    );

    paqi_lane u_lane_p25
    (
        .clk    (clk),
        .en     (en),
        .coarse (1'b0),
        .conc   (pm25_tenths),
        .sub    (sub_p25)
    );

    paqi_lane u_lane_p10
    (
        .clk    (clk),
        .en     (en),
        .coarse (1'b1),
        .conc   ({2'b00, pm10_whole}),
        .sub    (sub_p10)
    );

    always_comb
    begin
        s_p1  = sub_p1.ok  ? $signed({1'b0, sub_p1.value})  : -10'sd1;
        s_p25 = sub_p25.ok ? $signed({1'b0, sub_p25.value}) : -10'sd1;
        s_p10 = sub_p10.ok ? $signed({1'b0, sub_p10.value}) : -10'sd1;
        best_next = s_p1;
        if (s_p25 > best_next)
        begin
            best_next = s_p25;
        end
        if (s_p10 > best_next)
        begin
            best_next = s_p10;
        end
        if (best_next <= 10'sd50)
        begin
            cat_next = paqi_pkg::CAT_GOOD;
        end
        else if (best_next <= 10'sd100)
        begin
            cat_next = paqi_pkg::CAT_MODERATE;
        end
        else if (best_next <= 10'sd150)
        begin
            cat_next = paqi_pkg::CAT_SENSITIVE;
        end
        else if (best_next <= 10'sd200)
        begin
            cat_next = paqi_pkg::CAT_UNHEALTHY;
        end
        else if (best_next <= 10'sd300)
        begin
            cat_next = paqi_pkg::CAT_VERY_UNHEALTHY;
        end
        else
        begin
            cat_next = paqi_pkg::CAT_HAZARDOUS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_reg <= best_next;
            cat_reg  <= cat_next;
        end
    end

    assign out_valid       = v_reg[STAGES-1];
    assign index_value     = best_reg;
    assign health_category = cat_reg;

    `CHK_IMPLIES(a_none_is_good, out_valid && index_value == -10'sd1, health_category == 3'd0)
    `CHK_IMPLIES(a_index_range, out_valid, index_value >= -10'sd1 && index_value <= 10'sd500)
    `CHK_NEXT(a_accept_enters, in_valid && in_ready, v_reg[0])
    `CHK_IMPLIES(a_stall_only_on_hold, !in_ready, out_valid && !out_ready)

endmodule
